@@ design/gn2d_pkg.sv @@
// shared constants for the gradient noise pixel pipeline
// no dependencies
`default_nettype none
package gn2d_pkg;
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;
    localparam logic CFG_STEP_X = 1'b0;
    localparam logic CFG_STEP_Y = 1'b1;
    localparam int CFG_W = 22;
    localparam int PIX_W = 12;
    localparam int GRAD_W = 16;
    // lattice points per axis, tied to the 6-bit lattice ports
    localparam int GRID_POINTS = 64;
endpackage
`default_nettype wire

@@ design/gradient_noise_2d_pixel.sv @@
// gradient noise pixel generator top level
// uses gn2d_pkg
//
// one request channel (valid/ready) carries either a gradient write (func 0)
// or a pixel evaluation (func 1); a pixel yields one result on the output
// channel (gray, out_of_grid), a write yields nothing
// pipeline of 8 register stages; one request is taken every cycle while the
// output side keeps up; the rate is set by the single-item-per-stage pipeline
// the gradient table is held in four banks split by row and column parity,
// so the four corners of a cell are read together from distinct banks
// a write updates its bank when it passes stage 1, so pixels behind it see it
// when the receiver stalls with a result at the output, the whole pipeline
// holds and ready drops; no request is lost or repeated
// reset clears valid bits and sets both steps to 1.0; table entries are
// undefined until written
// config: cfg_we, cfg_index, cfg_data write step_x (0) or step_y (1)
`default_nettype none
module gradient_noise_2d_pixel
    import gn2d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic func,
    input  wire logic [PIX_W-1:0] pixel_col,
    input  wire logic [PIX_W-1:0] pixel_row,
    input  wire logic [5:0] lattice_col,
    input  wire logic [5:0] lattice_row,
    input  wire logic signed [GRAD_W-1:0] grad_dx,
    input  wire logic signed [GRAD_W-1:0] grad_dy,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [7:0] gray,
    output logic out_of_grid
);
    localparam int F = FRAC_BITS;
    localparam int IW = $clog2(GRID_POINTS);
    localparam int HW = (IW > 1) ? IW - 1 : 1;
    localparam int BD = (GRID_POINTS / 2) * (GRID_POINTS / 2);
    localparam int BAW = 2 * HW;
    localparam int PW = PIX_W + CFG_W;
    localparam int CW = PW - F;
    localparam int VW = F + 34;
    localparam int NS = 8;

    logic [CFG_W-1:0] step_x_reg, step_y_reg;
    logic [NS:1] v_reg;
    logic adv;
    assign adv = out_ready || !out_valid;
    assign in_ready = adv;
    assign out_valid = v_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg <= CFG_W'(1 << F);
            step_y_reg <= CFG_W'(1 << F);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_X: step_x_reg <= cfg_data;
                CFG_STEP_Y: step_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-1:1], in_valid && func == FUNC_PIXEL};
    end

    // stage 1: scale and register writes
    logic [PW-1:0] x1_reg, y1_reg;
    logic w1_reg;
    logic [5:0] lc1_reg, lr1_reg;
    logic [31:0] g1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w1_reg <= 1'b0;
        else if (adv)
            w1_reg <= in_valid && func == FUNC_WRITE && 32'(lattice_col) < GRID_POINTS
                      && 32'(lattice_row) < GRID_POINTS;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= PW'(pixel_col) * PW'(step_x_reg);
            y1_reg <= PW'(pixel_row) * PW'(step_y_reg);
            lc1_reg <= lattice_col;
            lr1_reg <= lattice_row;
            g1_reg <= {grad_dy, grad_dx};
        end
    end

    // stage 2: split, table read, start fade
    logic [31:0] bank00 [BD], bank01 [BD], bank10 [BD], bank11 [BD];
    logic [IW-1:0] wc, wr;
    logic [BAW-1:0] waddr;
    assign wc = lc1_reg[IW-1:0];
    assign wr = lr1_reg[IW-1:0];
    assign waddr = {wr[IW-1:IW-HW], wc[IW-1:IW-HW]};
    always_ff @(posedge clk)
    begin
        if (adv && w1_reg)
        begin
            case ({wr[0], wc[0]})
                2'b00: bank00[waddr] <= g1_reg;
                2'b01: bank01[waddr] <= g1_reg;
                2'b10: bank10[waddr] <= g1_reg;
                default: bank11[waddr] <= g1_reg;
            endcase
        end
    end

    logic [CW-1:0] cx, cy;
    logic [IW-1:0] x0, y0, x1p, y1p;
    logic oob;
    assign cx = x1_reg[PW-1:F];
    assign cy = y1_reg[PW-1:F];
    assign oob = (CW+1)'(cx) + 1'b1 >= (CW+1)'(GRID_POINTS)
              || (CW+1)'(cy) + 1'b1 >= (CW+1)'(GRID_POINTS);
    assign x0 = cx[IW-1:0];
    assign y0 = cy[IW-1:0];
    assign x1p = x0 + 1'b1;
    assign y1p = y0 + 1'b1;
    // each bank gets the row/column of whichever corner has its parity
    logic [IW-1:0] ce, co, re, ro;
    assign ce = x0[0] ? x1p : x0;
    assign co = x0[0] ? x0 : x1p;
    assign re = y0[0] ? y1p : y0;
    assign ro = y0[0] ? y0 : y1p;

    logic [31:0] q00_reg, q01_reg, q10_reg, q11_reg;
    logic [F-1:0] fx2_reg, fy2_reg;
    logic [F:0] tx2_reg, ty2_reg;
    logic oob2_reg, sx2_reg, sy2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q00_reg <= bank00[{re[IW-1:IW-HW], ce[IW-1:IW-HW]}];
            q01_reg <= bank01[{re[IW-1:IW-HW], co[IW-1:IW-HW]}];
            q10_reg <= bank10[{ro[IW-1:IW-HW], ce[IW-1:IW-HW]}];
            q11_reg <= bank11[{ro[IW-1:IW-HW], co[IW-1:IW-HW]}];
            fx2_reg <= x1_reg[F-1:0];
            fy2_reg <= y1_reg[F-1:0];
            tx2_reg <= (F+1)'(({F'(0), x1_reg[F-1:0]} * {F'(0), x1_reg[F-1:0]}) >> F);
            ty2_reg <= (F+1)'(({F'(0), y1_reg[F-1:0]} * {F'(0), y1_reg[F-1:0]}) >> F);
            oob2_reg <= oob;
            sx2_reg <= x0[0];
            sy2_reg <= y0[0];
        end
    end

    // stage 3: fade finish and corner dot products
    logic [31:0] ga, gb, gc, gd;
    always_comb
    begin
        // a=(x0,y0) b=(x0+1,y0) c=(x0,y0+1) d=(x0+1,y0+1)
        case ({sy2_reg, sx2_reg})
            2'b00: begin ga = q00_reg; gb = q01_reg; gc = q10_reg; gd = q11_reg; end
            2'b01: begin ga = q01_reg; gb = q00_reg; gc = q11_reg; gd = q10_reg; end
            2'b10: begin ga = q10_reg; gb = q11_reg; gc = q00_reg; gd = q01_reg; end
            default: begin ga = q11_reg; gb = q10_reg; gc = q01_reg; gd = q00_reg; end
        endcase
    end

    function automatic logic signed [VW-1:0] dotp(input logic [31:0] g,
                                                  input logic signed [F+1:0] ox,
                                                  input logic signed [F+1:0] oy);
        logic signed [VW-1:0] a, b;
        a = VW'(ox) * VW'($signed(g[15:0]));
        b = VW'(oy) * VW'($signed(g[31:16]));
        return a + b;
    endfunction

    logic signed [F+1:0] ox0, ox1, oy0, oy1;
    assign ox0 = $signed({2'b00, fx2_reg});
    assign oy0 = $signed({2'b00, fy2_reg});
    assign ox1 = ox0 - $signed((F+2)'(1 << F));
    assign oy1 = oy0 - $signed((F+2)'(1 << F));

    logic signed [VW-1:0] na3_reg, nb3_reg, nc3_reg, nd3_reg;
    logic [F:0] sx3_reg, sy3_reg;
    logic oob3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            na3_reg <= dotp(ga, ox0, oy0);
            nb3_reg <= dotp(gb, ox1, oy0);
            nc3_reg <= dotp(gc, ox0, oy1);
            nd3_reg <= dotp(gd, ox1, oy1);
            sx3_reg <= (F+1)'((((F+3)'(3) << F) - ((F+3)'(fx2_reg) << 1))
                              * (2*F+4)'(tx2_reg) >> F);
            sy3_reg <= (F+1)'((((F+3)'(3) << F) - ((F+3)'(fy2_reg) << 1))
                              * (2*F+4)'(ty2_reg) >> F);
            oob3_reg <= oob2_reg;
        end
    end

    // stage 4: differences; stage 5: x lerp products; stage 6: add; stage 7: y lerp product
    localparam int PRW = VW + F + 2;
    logic signed [VW-1:0] da4_reg, dc4_reg, na4_reg, nc4_reg;
    logic [F:0] sx4_reg, sy4_reg, sy5_reg, sy6_reg, sy7_reg;
    logic oob4_reg, oob5_reg, oob6_reg, oob7_reg;
    logic signed [PRW-1:0] pu5_reg, pv5_reg;
    logic signed [VW-1:0] na5_reg, nc5_reg, u6_reg, v6_reg, u7_reg;
    logic signed [PRW-1:0] pm7_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            da4_reg <= nb3_reg - na3_reg;
            dc4_reg <= nd3_reg - nc3_reg;
            na4_reg <= na3_reg;
            nc4_reg <= nc3_reg;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
            oob4_reg <= oob3_reg;

            pu5_reg <= PRW'(da4_reg) * $signed({1'b0, sx4_reg});
            pv5_reg <= PRW'(dc4_reg) * $signed({1'b0, sx4_reg});
            na5_reg <= na4_reg;
            nc5_reg <= nc4_reg;
            sy5_reg <= sy4_reg;
            oob5_reg <= oob4_reg;

            u6_reg <= na5_reg + VW'(pu5_reg >>> F);
            v6_reg <= nc5_reg + VW'(pv5_reg >>> F);
            sy6_reg <= sy5_reg;
            oob6_reg <= oob5_reg;

            pm7_reg <= PRW'(v6_reg - u6_reg) * $signed({1'b0, sy6_reg});
            u7_reg <= u6_reg;
            sy7_reg <= sy6_reg;
            oob7_reg <= oob6_reg;
        end
    end

    // stage 8: final lerp, offset, clamp, scale
    logic signed [VW-1:0] m8;
    logic [F+14:0] mc;
    logic [F+22:0] ms;
    always_comb
    begin
        m8 = u7_reg + VW'(pm7_reg >>> F) + (VW'(1) <<< (F + 13));
        if (m8 < 0)
            mc = '0;
        else if (m8 > (VW'(1) <<< (F + 14)))
            mc = (F+15)'(1) << (F + 14);
        else
            mc = m8[F+14:0];
        ms = (F+23)'(mc) * (F+23)'(255);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gray <= oob7_reg ? 8'd0 : ms[F+21:F+14];
            out_of_grid <= oob7_reg;
        end
    end
endmodule
`default_nettype wire

@@ design/gn2d_checker.sv @@
// port-level checks for the gradient noise pipeline
// bound to gradient_noise_2d_pixel, uses no package
`default_nettype none
module gn2d_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [7:0] gray,
    input wire logic out_of_grid
);
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (out_ready || !out_valid)) else $error("ready mismatch");
    a_oob_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_grid |-> gray == 8'd0) else $error("oob gray");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gray) && $stable(out_of_grid))
        else $error("stalled result changed");
endmodule

bind gradient_noise_2d_pixel gn2d_checker u_gn2d_checker (.*);
`default_nettype wire

@@ sim/gradient_noise_2d_pixel_tb.sv @@
// self-checking testbench for the gradient noise pixel pipeline
// depends on gn2d_pkg and gradient_noise_2d_pixel; predicts every pixel result in fixed point
`default_nettype none
module gradient_noise_2d_pixel_tb;
    import gn2d_pkg::*;

    typedef struct {
        logic               fn;
        logic [PIX_W-1:0]   pcol;
        logic [PIX_W-1:0]   prow;
        logic [5:0]         lcol;
        logic [5:0]         lrow;
        logic [GRAD_W-1:0]  dx;
        logic [GRAD_W-1:0]  dy;
    } noise_req_t;

    typedef struct {
        logic [7:0] gray;
        logic       oog;
    } gray_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_STEP_X;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = FUNC_WRITE;
    logic [PIX_W-1:0] pixel_col = '0;
    logic [PIX_W-1:0] pixel_row = '0;
    logic [5:0] lattice_col = '0;
    logic [5:0] lattice_row = '0;
    logic signed [GRAD_W-1:0] grad_dx = '0;
    logic signed [GRAD_W-1:0] grad_dy = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] gray;
    logic out_of_grid;

    gradient_noise_2d_pixel dut (.*);

    always #4 clk = ~clk;

    // predictor state, updated as requests are taken
    logic [31:0] grad_table [0:4095];
    longint unsigned step_x_q = 65536;
    longint unsigned step_y_q = 65536;

    // generator view: steps of the current phase and which entries hold a gradient
    longint unsigned gen_step_x = 65536;
    longint unsigned gen_step_y = 65536;
    bit gen_written [0:4095];

    noise_req_t pending_reqs [$];
    noise_req_t cur_req;
    gray_res_t  expected_grays [$];
    bit hold_send = 1'b0;
    bit no_idle = 1'b0;
    int errors = 0;

    function automatic longint fade_q(longint t);
        longint t2;
        t2 = (t * t) >>> 16;
        return ((3 * 65536 - 2 * t) * t2) >>> 16;
    endfunction

    function automatic longint lerp_q(longint a, longint b, longint s);
        return a + ((s * (b - a)) >>> 16);
    endfunction

    function automatic longint corner_dot(longint col, longint row, longint ox, longint oy);
        logic [31:0] e;
        e = grad_table[row * 64 + col];
        return ox * longint'($signed(e[15:0])) + oy * longint'($signed(e[31:16]));
    endfunction

    function automatic gray_res_t noise_gray(noise_req_t r);
        gray_res_t res;
        longint x, y, x0, y0, fx, fy, sx, sy, u, v, m;
        x = longint'(r.pcol) * longint'(step_x_q);
        y = longint'(r.prow) * longint'(step_y_q);
        x0 = x >>> 16;
        y0 = y >>> 16;
        res.gray = 8'd0;
        res.oog = 1'b1;
        if (x0 + 1 >= 64 || y0 + 1 >= 64)
            return res;
        fx = x & 65535;
        fy = y & 65535;
        sx = fade_q(fx);
        sy = fade_q(fy);
        u = lerp_q(corner_dot(x0, y0, fx, fy), corner_dot(x0 + 1, y0, fx - 65536, fy), sx);
        v = lerp_q(corner_dot(x0, y0 + 1, fx, fy - 65536),
                   corner_dot(x0 + 1, y0 + 1, fx - 65536, fy - 65536), sx);
        m = lerp_q(u, v, sy) + (longint'(1) << 29);
        if (m < 0)
            m = 0;
        if (m > (longint'(1) << 30))
            m = longint'(1) << 30;
        res.gray = 8'((m * 255) >>> 30);
        res.oog = 1'b0;
        return res;
    endfunction

    function automatic logic [GRAD_W-1:0] rand_grad();
        if ($urandom_range(9) < 7)
            return GRAD_W'($urandom_range(32768) - 16384);
        return GRAD_W'($urandom);
    endfunction

    function automatic void push_write(int lc, int lr, logic [GRAD_W-1:0] dx,
                                       logic [GRAD_W-1:0] dy);
        noise_req_t r;
        r.fn = FUNC_WRITE;
        r.pcol = PIX_W'($urandom);
        r.prow = PIX_W'($urandom);
        r.lcol = 6'(lc);
        r.lrow = 6'(lr);
        r.dx = dx;
        r.dy = dy;
        gen_written[lr * 64 + lc] = 1'b1;
        pending_reqs.push_back(r);
    endfunction

    // a pixel whose cell is in the grid gets its missing corners written first, and others at random
    function automatic void push_pixel(int pc, int pr);
        noise_req_t r;
        longint x0, y0;
        x0 = (longint'(pc) * longint'(gen_step_x)) >>> 16;
        y0 = (longint'(pr) * longint'(gen_step_y)) >>> 16;
        if (x0 + 1 < 64 && y0 + 1 < 64)
            for (int j = 0; j < 2; j++)
                for (int i = 0; i < 2; i++)
                    if (!gen_written[(y0 + j) * 64 + x0 + i] || $urandom_range(3) == 0)
                        push_write(int'(x0) + i, int'(y0) + j, rand_grad(), rand_grad());
        r.fn = FUNC_PIXEL;
        r.pcol = PIX_W'(pc);
        r.prow = PIX_W'(pr);
        r.lcol = 6'($urandom);
        r.lrow = 6'($urandom);
        r.dx = GRAD_W'($urandom);
        r.dy = GRAD_W'($urandom);
        pending_reqs.push_back(r);
    endfunction

    function automatic int pix_limit(longint unsigned stp);
        longint lim;
        if (stp == 0)
            return 4095;
        lim = (longint'(64) << 16) / longint'(stp) + 1;
        return (lim > 4095) ? 4095 : int'(lim);
    endfunction

    function automatic void push_random(int n);
        int lx, ly;
        lx = pix_limit(gen_step_x);
        ly = pix_limit(gen_step_y);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 3)
                push_write($urandom_range(63), $urandom_range(63), rand_grad(), rand_grad());
            else if ($urandom_range(9) == 0)
                push_pixel($urandom_range(4095), $urandom_range(4095));
            else
                push_pixel($urandom_range(lx), $urandom_range(ly));
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready) begin
            if (in_valid) begin
                if (cur_req.fn == FUNC_WRITE)
                    grad_table[{cur_req.lrow, cur_req.lcol}] = {cur_req.dy, cur_req.dx};
                else
                    expected_grays.push_back(noise_gray(cur_req));
            end
            if (pending_reqs.size() != 0 && !hold_send
                && (no_idle || $urandom_range(99) >= 24)) begin
                cur_req = pending_reqs.pop_front();
                func <= cur_req.fn;
                pixel_col <= cur_req.pcol;
                pixel_row <= cur_req.prow;
                lattice_col <= cur_req.lcol;
                lattice_row <= cur_req.lrow;
                grad_dx <= cur_req.dx;
                grad_dy <= cur_req.dy;
                in_valid <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n) begin
        gray_res_t exp_r;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_grays.size() == 0) begin
                    $error("unexpected result gray=%0d out_of_grid=%0d", gray, out_of_grid);
                    errors++;
                end
                else begin
                    exp_r = expected_grays.pop_front();
                    if (gray !== exp_r.gray) begin
                        $error("gray expected %0d actual %0d", exp_r.gray, gray);
                        errors++;
                    end
                    if (out_of_grid !== exp_r.oog) begin
                        $error("out_of_grid expected %0d actual %0d", exp_r.oog, out_of_grid);
                        errors++;
                    end
                end
            end
            out_ready <= no_idle || ($urandom_range(99) >= 24);
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_grays.size() != 0)
            @(posedge clk);
        // trailing writes may still be in the pipeline
        repeat (12) @(posedge clk);
    endtask

    task automatic write_steps(longint unsigned sx, longint unsigned sy);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STEP_X;
        cfg_data <= CFG_W'(sx);
        @(posedge clk);
        cfg_index <= CFG_STEP_Y;
        cfg_data <= CFG_W'(sy);
        @(posedge clk);
        cfg_we <= 1'b0;
        step_x_q = sx;
        step_y_q = sy;
        gen_step_x = sx;
        gen_step_y = sy;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset steps: fraction is zero, so the noise value is zero; cover edges of the grid
        push_write(0, 0, 16'sd16384, -16'sd16384);
        push_write(1, 0, 16'h8000, 16'h7FFF);
        push_write(0, 1, 16'hFFFF, 16'h0000);
        push_write(1, 1, 16'h7FFF, 16'h8000);
        push_write(63, 63, 16'h5555, 16'hAAAA);
        push_pixel(0, 0);
        push_pixel(62, 62);
        push_pixel(63, 0);
        push_pixel(0, 63);
        push_pixel(4095, 4095);
        wait_drained();

        // fractional steps with oversized gradients drive the clamp both ways
        write_steps(22'h00C000, 22'h00A000);
        push_write(1, 1, 16'h7FFF, 16'h7FFF);
        push_write(2, 1, 16'h8000, 16'h8000);
        push_write(1, 2, 16'h8000, 16'h7FFF);
        push_write(2, 2, 16'h7FFF, 16'h8000);
        push_pixel(2, 2);
        push_write(1, 1, 16'h8000, 16'h8000);
        push_pixel(2, 2);
        push_pixel(3, 3);
        push_random(25);
        // let every result out before sending more
        hold_send = 1'b1;
        while (in_valid || expected_grays.size() != 0)
            @(posedge clk);
        hold_send = 1'b0;
        push_random(25);
        wait_drained();

        write_steps(22'h000000, 22'h3FFFFF);
        push_random(15);
        wait_drained();

        write_steps(22'h3FFFFF, 22'h000000);
        push_random(15);
        wait_drained();

        write_steps(22'h001000, 22'h0002BC);
        push_random(40);
        no_idle = 1'b1;
        wait_drained();
        push_random(45);
        wait_drained();
        no_idle = 1'b0;

        for (int p = 0; p < 3; p++) begin
            write_steps(longint'($urandom_range(22'h3FFFFF)) >> $urandom_range(8),
                        longint'($urandom_range(22'h3FFFFF)) >> $urandom_range(8));
            push_random(25);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (errors == 0 && expected_grays.size() == 0)
            $display("gradient_noise_2d_pixel verification clean");
        else
            $display("gradient_noise_2d_pixel verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("gradient_noise_2d_pixel verification failed");
        $finish;
    end
endmodule
`default_nettype wire
